// ===== src/meiu_pkg.sv =====
// ----------------------------------------------------------------------------
// meiu_pkg
// Shared types and constants of the CP0 exception and interrupt unit:
// request codes, register selects, CP0 bit positions and vector addresses.
// ----------------------------------------------------------------------------
package meiu_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned NUM_IRQ  = 8;
    localparam int unsigned CFG_IDXW = 1;

    // request codes
    localparam logic [3:0] REQ_SET_IRQ = 4'd0;
    localparam logic [3:0] REQ_CLR_IRQ = 4'd1;
    localparam logic [3:0] REQ_POLL    = 4'd2;
    localparam logic [3:0] REQ_EXC     = 4'd3;
    localparam logic [3:0] REQ_COPU    = 4'd4;
    localparam logic [3:0] REQ_ERET    = 4'd5;
    localparam logic [3:0] REQ_DERET   = 4'd6;
    localparam logic [3:0] REQ_DEBUG   = 4'd7;
    localparam logic [3:0] REQ_WRITE   = 4'd8;
    localparam logic [3:0] REQ_READ    = 4'd9;

    // register selects
    localparam logic [2:0] SEL_STATUS = 3'd0;
    localparam logic [2:0] SEL_CAUSE  = 3'd1;
    localparam logic [2:0] SEL_EPC    = 3'd2;
    localparam logic [2:0] SEL_ERREPC = 3'd3;
    localparam logic [2:0] SEL_DEPC   = 3'd4;
    localparam logic [2:0] SEL_DEBUG  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDXW-1:0] CFG_EXC_BASE  = 1'd0;
    localparam logic [CFG_IDXW-1:0] CFG_PRIO_MODE = 1'd1;

    // exception codes; INT, TLBL and TLBS have special vectors
    localparam logic [4:0] EXC_INT  = 5'd0;
    localparam logic [4:0] EXC_TLBL = 5'd2;
    localparam logic [4:0] EXC_TLBS = 5'd3;
    localparam logic [4:0] EXC_CPU  = 5'd11;

    // status bits
    localparam int unsigned ST_IE  = 0;
    localparam int unsigned ST_EXL = 1;
    localparam int unsigned ST_ERL = 2;
    localparam int unsigned ST_BEV = 22;

    // cause bits
    localparam int unsigned CA_IV = 23;
    localparam int unsigned CA_BD = 31;

    // debug bits
    localparam logic [XLEN-1:0] DB_TYPE = 32'h000C_7C3F;
    localparam int unsigned     DB_IEXI = 20;
    localparam int unsigned     DB_DM   = 30;
    localparam int unsigned     DB_DBD  = 31;

    // vectors, offsets and reset values
    localparam logic [XLEN-1:0] BOOT_BASE     = 32'hBFC0_0200;
    localparam logic [XLEN-1:0] DEBUG_VEC     = 32'hBFC0_0480;
    localparam logic [XLEN-1:0] EBASE_RESET   = 32'h8000_0000;
    localparam logic [XLEN-1:0] OFF_GEN       = 32'h0000_0180;
    localparam logic [XLEN-1:0] OFF_TLB       = 32'h0000_0000;
    localparam logic [XLEN-1:0] OFF_INT       = 32'h0000_0200;
    localparam logic [XLEN-1:0] STATUS_RESET  = 32'h0040_0000;

    typedef struct packed {
        logic [3:0]      req_type;
        logic [4:0]      cause_code;
        logic            in_delay_slot;
        logic [XLEN-1:0] cur_pc;
        logic            isa16;
        logic [2:0]      irq_line;
        logic [XLEN-1:0] debug_kind;
        logic [2:0]      reg_select;
        logic [XLEN-1:0] write_value;
    } meiu_in_t;

    typedef struct packed {
        logic            redirect;
        logic [XLEN-1:0] new_pc;
        logic            new_isa16;
        logic            clear_link;
        logic            int_pending;
        logic [XLEN-1:0] read_data;
    } meiu_out_t;

endpackage

// ===== src/mips_exception_interrupt_unit_top.sv =====
// ----------------------------------------------------------------------------
// mips_exception_interrupt_unit_top
// MIPS32 CP0 exception and interrupt unit: interrupt lines, exception entry,
// ERET/DERET, debug exception entry and CP0 register access.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle, sustained while m_ready is high. Each
// request waits in the input register until the result register is free or
// its result is being taken, and then moves into the result register, which
// offers it on m_valid. The input register holds a further request while a
// result waits, so the unit keeps accepting until both registers are full.
// All CP0 state is updated at the edge on which a request moves from the
// input register to the result register.
// ----------------------------------------------------------------------------
module mips_exception_interrupt_unit_top
    import meiu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  meiu_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output meiu_out_t           m_data,
    input  logic                cfg_we,
    input  logic [CFG_IDXW-1:0] cfg_index,
    input  logic [XLEN-1:0]     cfg_wdata
);

    logic            in_valid_reg;
    meiu_in_t        in_data_reg;
    logic            out_valid_reg;
    meiu_out_t       out_data_reg;
    meiu_out_t       out_data_next;
    logic            advance;

    logic [XLEN-1:0] exception_base_reg;
    logic            prio_mode_reg;

    logic [XLEN-1:0] status_reg, status_next;
    logic [XLEN-1:0] cause_reg, cause_next;
    logic [XLEN-1:0] epc_reg, epc_next;
    logic [XLEN-1:0] error_epc_reg, error_epc_next;
    logic [XLEN-1:0] depc_reg, depc_next;
    logic [XLEN-1:0] debug_reg, debug_next;
    logic [NUM_IRQ-1:0] lines_reg, lines_next;
    logic            pending_reg, pending_next;

    logic [XLEN-1:0] cause_pre;
    logic            take_exc;
    logic [4:0]      exc_sel;
    logic            exc_bd;
    logic            irq_ok;
    logic [XLEN-1:0] vec_base;
    logic [XLEN-1:0] vec_off;
    logic [XLEN-1:0] ret_pc;
    logic [XLEN-1:0] pc_isa;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign pc_isa  = in_data_reg.cur_pc | {{(XLEN-1){1'b0}}, in_data_reg.isa16};

    always_comb begin
        status_next    = status_reg;
        cause_next     = cause_reg;
        epc_next       = epc_reg;
        error_epc_next = error_epc_reg;
        depc_next      = depc_reg;
        debug_next     = debug_reg;
        lines_next     = lines_reg;
        pending_next   = pending_reg;
        out_data_next  = '0;
        cause_pre      = cause_reg;
        take_exc       = 1'b0;
        exc_sel        = EXC_INT;
        exc_bd         = 1'b0;
        irq_ok         = 1'b0;
        vec_base       = '0;
        vec_off        = OFF_GEN;
        ret_pc         = '0;

        case (in_data_reg.req_type)
            REQ_SET_IRQ: begin
                lines_next = lines_reg | (NUM_IRQ'(1) << in_data_reg.irq_line);
            end
            REQ_CLR_IRQ: begin
                lines_next = lines_reg & ~(NUM_IRQ'(1) << in_data_reg.irq_line);
                if (lines_next == '0) begin
                    pending_next = 1'b0;
                end
            end
            REQ_POLL: begin
                cause_pre  = {cause_reg[31:16], lines_reg, cause_reg[7:0]};
                cause_next = cause_pre;
                if (status_reg[ST_IE] && !status_reg[ST_EXL] && !status_reg[ST_ERL]) begin
                    if (prio_mode_reg) begin
                        irq_ok = cause_pre[15:10] > status_reg[15:10];
                    end else begin
                        irq_ok = (cause_pre[15:8] & status_reg[15:8]) != '0;
                    end
                end
                pending_next = irq_ok;
                take_exc     = irq_ok;
            end
            REQ_EXC: begin
                take_exc = 1'b1;
                exc_sel  = in_data_reg.cause_code;
                exc_bd   = in_data_reg.in_delay_slot;
            end
            REQ_COPU: begin
                cause_pre = {cause_reg[31:30], 2'b01, cause_reg[27:0]};
                take_exc  = 1'b1;
                exc_sel   = EXC_CPU;
                exc_bd    = in_data_reg.in_delay_slot;
            end
            REQ_ERET: begin
                if (status_reg[ST_ERL]) begin
                    status_next[ST_ERL] = 1'b0;
                    ret_pc = error_epc_reg;
                end else begin
                    status_next[ST_EXL] = 1'b0;
                    ret_pc = epc_reg;
                end
                out_data_next.redirect   = 1'b1;
                out_data_next.clear_link = 1'b1;
                out_data_next.new_isa16  = ret_pc[0];
                out_data_next.new_pc     = {ret_pc[XLEN-1:1], 1'b0};
            end
            REQ_DERET: begin
                debug_next[DB_DM]       = 1'b0;
                debug_next[DB_IEXI]     = 1'b0;
                out_data_next.redirect  = 1'b1;
                out_data_next.new_isa16 = depc_reg[0];
                out_data_next.new_pc    = {depc_reg[XLEN-1:1], 1'b0};
            end
            REQ_DEBUG: begin
                debug_next          = (debug_reg & ~DB_TYPE) | in_data_reg.debug_kind;
                debug_next[DB_DBD]  = in_data_reg.in_delay_slot;
                debug_next[DB_DM]   = 1'b1;
                debug_next[DB_IEXI] = 1'b1;
                depc_next           = pc_isa;
                pending_next        = 1'b0;
                out_data_next.redirect = 1'b1;
                out_data_next.new_pc   = DEBUG_VEC;
            end
            REQ_WRITE: begin
                case (in_data_reg.reg_select)
                    SEL_STATUS: status_next    = in_data_reg.write_value;
                    SEL_CAUSE:  cause_next     = in_data_reg.write_value;
                    SEL_EPC:    epc_next       = in_data_reg.write_value;
                    SEL_ERREPC: error_epc_next = in_data_reg.write_value;
                    SEL_DEPC:   depc_next      = in_data_reg.write_value;
                    SEL_DEBUG:  debug_next     = in_data_reg.write_value;
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (in_data_reg.reg_select)
                    SEL_STATUS: out_data_next.read_data = status_reg;
                    SEL_CAUSE:  out_data_next.read_data = cause_reg;
                    SEL_EPC:    out_data_next.read_data = epc_reg;
                    SEL_ERREPC: out_data_next.read_data = error_epc_reg;
                    SEL_DEPC:   out_data_next.read_data = depc_reg;
                    SEL_DEBUG:  out_data_next.read_data = debug_reg;
                    default:    out_data_next.read_data = '0;
                endcase
            end
            default: ;
        endcase

        if (take_exc) begin
            cause_next = cause_pre;
            if (!status_reg[ST_EXL]) begin
                epc_next          = pc_isa;
                cause_next[CA_BD] = exc_bd;
                if (exc_sel inside {EXC_TLBL, EXC_TLBS}) begin
                    vec_off = OFF_TLB;
                end else if (exc_sel == EXC_INT && cause_pre[CA_IV]) begin
                    vec_off = OFF_INT;
                end
            end
            cause_next[6:2] = exc_sel;
            if (exc_sel == EXC_INT) begin
                lines_next = '0;
            end
            status_next[ST_EXL] = 1'b1;
            status_next[ST_ERL] = 1'b0;
            pending_next        = 1'b0;
            vec_base = status_reg[ST_BEV] ? BOOT_BASE : exception_base_reg;
            out_data_next.redirect = 1'b1;
            out_data_next.new_pc   = vec_base + vec_off;
        end

        out_data_next.int_pending = pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            exception_base_reg <= EBASE_RESET;
            prio_mode_reg      <= 1'b0;
            status_reg         <= STATUS_RESET;
            cause_reg          <= '0;
            epc_reg            <= '0;
            error_epc_reg      <= '0;
            depc_reg           <= '0;
            debug_reg          <= '0;
            lines_reg          <= '0;
            pending_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EXC_BASE:  exception_base_reg <= cfg_wdata;
                    CFG_PRIO_MODE: prio_mode_reg      <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                cause_reg     <= cause_next;
                epc_reg       <= epc_next;
                error_epc_reg <= error_epc_next;
                depc_reg      <= depc_next;
                debug_reg     <= debug_next;
                lines_reg     <= lines_next;
                pending_reg   <= pending_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== src/meiu_checker.sv =====
// ----------------------------------------------------------------------------
// meiu_checker
// Port-level checks of the CP0 exception and interrupt unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module meiu_checker
    import meiu_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input meiu_out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.redirect |-> m_data.new_pc == '0 && !m_data.new_isa16)
        else $error("target given without redirect");

    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clear_link |-> m_data.redirect && !m_data.int_pending)
        else $error("link clear outside a return");

    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_data != '0 |-> !m_data.redirect)
        else $error("read data on a redirecting transfer");

endmodule

bind mips_exception_interrupt_unit_top meiu_checker u_meiu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/mips_exception_interrupt_unit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mips_exception_interrupt_unit_top_tb
// Self-checking bench for the CP0 exception and interrupt unit. A scoreboard
// class keeps its own copy of the CP0 state and the vector configuration,
// works out the response to every request the unit accepts and compares each
// response the unit returns, field by field, in order. Stimulus is a short
// directed list followed by randomised phases of well-formed interrupt,
// exception, debug and register sequences mixed with arbitrary requests,
// under random sender bursts and receiver back-pressure.
// ----------------------------------------------------------------------------
module mips_exception_interrupt_unit_top_tb;
    import meiu_pkg::*;

    localparam logic [3:0] REQ_UNUSED_TOP = 4'd15;
    localparam logic [2:0] SEL_UNUSED_LO  = 3'd6;
    localparam logic [2:0] SEL_UNUSED_HI  = 3'd7;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         HOLD_CYCLES    = 60;
    localparam int         MAX_SHOWN      = 10;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    class cp0_scoreboard_t;
        logic [XLEN-1:0]    ebase;
        logic               level_mode;
        logic [XLEN-1:0]    status, cause, epc, error_epc, depc, dbg;
        logic [NUM_IRQ-1:0] lines;
        logic               pending;
        meiu_out_t          awaited[$];
        int                 mismatches;

        function new();
            ebase      = EBASE_RESET;
            level_mode = 1'b0;
            status     = STATUS_RESET;
            cause      = '0;
            epc        = '0;
            error_epc  = '0;
            depc       = '0;
            dbg        = '0;
            lines      = '0;
            pending    = 1'b0;
            mismatches = 0;
        endfunction

        function void configure(input logic [CFG_IDXW-1:0] idx, input logic [XLEN-1:0] v);
            if (idx == CFG_EXC_BASE) begin
                ebase = v;
            end else begin
                level_mode = v[0];
            end
        endfunction

        function logic [XLEN-1:0] take_exception(input logic [4:0] code, input logic bd,
                                                 input logic [XLEN-1:0] pc, input logic i16);
            logic            was_exl;
            logic [XLEN-1:0] vec;
            was_exl = status[ST_EXL];
            if (!was_exl) begin
                epc = {pc[XLEN-1:1], pc[0] | i16};
                cause[CA_BD] = bd;
            end
            cause[6:2] = code;
            if (code == EXC_INT) begin
                lines = '0;
            end
            status[ST_EXL] = 1'b1;
            status[ST_ERL] = 1'b0;
            vec = (status[ST_BEV] ? BOOT_BASE : ebase) + OFF_GEN;
            if (!was_exl) begin
                if (code == EXC_TLBL || code == EXC_TLBS) begin
                    vec = vec - OFF_GEN + OFF_TLB;
                end else if (code == EXC_INT && cause[CA_IV]) begin
                    vec = vec - OFF_GEN + OFF_INT;
                end
            end
            pending = 1'b0;
            return vec;
        endfunction

        function void note_request(input meiu_in_t rq);
            meiu_out_t       rsp;
            logic [XLEN-1:0] t;
            rsp = '0;
            case (rq.req_type)
                REQ_SET_IRQ: begin
                    lines[rq.irq_line] = 1'b1;
                end
                REQ_CLR_IRQ: begin
                    lines[rq.irq_line] = 1'b0;
                    if (lines == '0) pending = 1'b0;
                end
                REQ_POLL: begin
                    cause[15:8] = lines;
                    if (!status[ST_IE] || status[ST_EXL] || status[ST_ERL]) begin
                        pending = 1'b0;
                    end else if (level_mode) begin
                        pending = cause[15:10] > status[15:10];
                    end else begin
                        pending = |(cause[15:8] & status[15:8]);
                    end
                    if (pending) begin
                        rsp.new_pc   = take_exception(EXC_INT, 1'b0, rq.cur_pc, rq.isa16);
                        rsp.redirect = 1'b1;
                    end
                end
                REQ_EXC: begin
                    rsp.new_pc   = take_exception(rq.cause_code, rq.in_delay_slot, rq.cur_pc,
                                                  rq.isa16);
                    rsp.redirect = 1'b1;
                end
                REQ_COPU: begin
                    cause[29:28] = 2'b01;
                    rsp.new_pc   = take_exception(EXC_CPU, rq.in_delay_slot, rq.cur_pc,
                                                  rq.isa16);
                    rsp.redirect = 1'b1;
                end
                REQ_ERET: begin
                    if (status[ST_ERL]) begin
                        status[ST_ERL] = 1'b0;
                        t = error_epc;
                    end else begin
                        status[ST_EXL] = 1'b0;
                        t = epc;
                    end
                    rsp.redirect   = 1'b1;
                    rsp.clear_link = 1'b1;
                    rsp.new_isa16  = t[0];
                    rsp.new_pc     = {t[XLEN-1:1], 1'b0};
                end
                REQ_DERET: begin
                    dbg[DB_DM]    = 1'b0;
                    dbg[DB_IEXI]  = 1'b0;
                    rsp.redirect  = 1'b1;
                    rsp.new_isa16 = depc[0];
                    rsp.new_pc    = {depc[XLEN-1:1], 1'b0};
                end
                REQ_DEBUG: begin
                    dbg          = (dbg & ~DB_TYPE) | rq.debug_kind;
                    dbg[DB_DBD]  = rq.in_delay_slot;
                    dbg[DB_DM]   = 1'b1;
                    dbg[DB_IEXI] = 1'b1;
                    depc         = {rq.cur_pc[XLEN-1:1], rq.cur_pc[0] | rq.isa16};
                    rsp.redirect = 1'b1;
                    rsp.new_pc   = DEBUG_VEC;
                    pending      = 1'b0;
                end
                REQ_WRITE: begin
                    case (rq.reg_select)
                        SEL_STATUS: status    = rq.write_value;
                        SEL_CAUSE:  cause     = rq.write_value;
                        SEL_EPC:    epc       = rq.write_value;
                        SEL_ERREPC: error_epc = rq.write_value;
                        SEL_DEPC:   depc      = rq.write_value;
                        SEL_DEBUG:  dbg       = rq.write_value;
                        default: ;
                    endcase
                end
                REQ_READ: begin
                    case (rq.reg_select)
                        SEL_STATUS: rsp.read_data = status;
                        SEL_CAUSE:  rsp.read_data = cause;
                        SEL_EPC:    rsp.read_data = epc;
                        SEL_ERREPC: rsp.read_data = error_epc;
                        SEL_DEPC:   rsp.read_data = depc;
                        SEL_DEBUG:  rsp.read_data = dbg;
                        default:    rsp.read_data = '0;
                    endcase
                end
                default: ;
            endcase
            rsp.int_pending = pending;
            awaited.push_back(rsp);
        endfunction

        function void check_result(input meiu_out_t got);
            meiu_out_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: response with none outstanding, new_pc=%h rdata=%h",
                             $realtime, got.new_pc, got.read_data);
                return;
            end
            want = awaited.pop_front();
            if (got.redirect !== want.redirect || got.new_pc !== want.new_pc ||
                got.new_isa16 !== want.new_isa16 || got.clear_link !== want.clear_link ||
                got.int_pending !== want.int_pending || got.read_data !== want.read_data) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: response mismatch", $realtime);
                    $display("  expected redir=%b pc=%h isa16=%b link=%b pend=%b rdata=%h",
                             want.redirect, want.new_pc, want.new_isa16, want.clear_link,
                             want.int_pending, want.read_data);
                    $display("  actual   redir=%b pc=%h isa16=%b link=%b pend=%b rdata=%h",
                             got.redirect, got.new_pc, got.new_isa16, got.clear_link,
                             got.int_pending, got.read_data);
                end
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    meiu_in_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    meiu_out_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [CFG_IDXW-1:0] cfg_index = '0;
    logic [XLEN-1:0]     cfg_wdata = '0;

    cp0_scoreboard_t book = new();
    int            live_items = 0;
    int            burst_left = 0;
    int            quiet      = 0;
    logic          long_hold  = 1'b0;

    mips_exception_interrupt_unit_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) book.note_request(s_data);
            if (m_valid && m_ready) book.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: pick a new random stall pattern whenever the current one runs out, hold off on request
    initial begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: m_ready <= ($urandom_range(0, 2) == 0);
                    default:  m_ready <= (left % 5 != 0);
                endcase
            end
        end
    end

    function automatic meiu_in_t plain_request(input logic [3:0] kind);
        meiu_in_t rq;
        rq = '0;
        rq.req_type = kind;
        return rq;
    endfunction

    function automatic meiu_in_t random_request();
        meiu_in_t rq;
        if ($urandom_range(0, 19) < 2) begin
            rq.req_type = 4'($urandom_range(10, 15));
        end else begin
            rq.req_type = 4'($urandom_range(0, 9));
        end
        rq.cause_code    = 5'($urandom);
        rq.in_delay_slot = 1'($urandom);
        rq.cur_pc        = $urandom;
        rq.isa16         = 1'($urandom);
        rq.irq_line      = 3'($urandom);
        rq.debug_kind    = $urandom;
        rq.reg_select    = 3'($urandom);
        rq.write_value   = $urandom;
        return rq;
    endfunction

    task automatic pause(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic offer(input meiu_in_t rq);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge aclk);
        s_data  <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (rq.req_type <= REQ_READ) live_items++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (book.awaited.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDXW-1:0] idx, input logic [XLEN-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        book.configure(idx, v);
    endtask

    task automatic run_phase(input logic [XLEN-1:0] base, input logic mode, input int n,
                             input logic hold);
        meiu_in_t rq;
        int       target;
        drain();
        set_register(CFG_EXC_BASE, base);
        set_register(CFG_PRIO_MODE, {{(XLEN-1){1'b0}}, mode});
        if (hold) long_hold = 1'b1;
        target = live_items + n;
        while (live_items < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: offer(random_request());
                3, 4, 5: begin
                    // interrupt service: enable, raise lines, poll, look, return
                    rq = random_request();
                    rq.req_type = REQ_WRITE;
                    rq.reg_select = SEL_STATUS;
                    rq.write_value[2:0] = 3'b001;
                    offer(rq);
                    repeat ($urandom_range(1, 3)) begin
                        rq = random_request();
                        rq.req_type = REQ_SET_IRQ;
                        offer(rq);
                    end
                    rq = random_request();
                    rq.req_type = REQ_POLL;
                    offer(rq);
                    rq = random_request();
                    rq.req_type = REQ_READ;
                    offer(rq);
                    rq = random_request();
                    rq.req_type = REQ_ERET;
                    offer(rq);
                end
                6, 7: begin
                    rq = random_request();
                    rq.req_type = ($urandom_range(0, 3) == 0) ? REQ_COPU : REQ_EXC;
                    if ($urandom_range(0, 1) == 0) rq.cause_code = 5'($urandom_range(0, 3));
                    offer(rq);
                    if ($urandom_range(0, 2) == 0) begin
                        rq = random_request();
                        rq.req_type = REQ_EXC;
                        offer(rq);
                    end
                    rq = random_request();
                    rq.req_type = REQ_READ;
                    offer(rq);
                    rq = random_request();
                    rq.req_type = REQ_ERET;
                    offer(rq);
                end
                8: begin
                    rq = random_request();
                    rq.req_type = REQ_DEBUG;
                    offer(rq);
                    rq = random_request();
                    rq.req_type = REQ_READ;
                    offer(rq);
                    rq = random_request();
                    rq.req_type = REQ_DERET;
                    offer(rq);
                end
                default: begin
                    rq = random_request();
                    rq.req_type = REQ_WRITE;
                    offer(rq);
                    rq.req_type = REQ_READ;
                    offer(rq);
                end
            endcase
        end
    endtask

    initial begin
        meiu_in_t rq;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        rq = plain_request(REQ_READ);
        rq.reg_select = SEL_STATUS;
        offer(rq);
        offer(plain_request(REQ_UNUSED_TOP));
        rq = plain_request(REQ_SET_IRQ);
        offer(rq);
        rq.irq_line = 3'd7;
        offer(rq);
        offer(plain_request(REQ_POLL));
        rq = plain_request(REQ_READ);
        rq.reg_select = SEL_CAUSE;
        offer(rq);
        rq = plain_request(REQ_WRITE);
        rq.reg_select = SEL_STATUS;
        rq.write_value = 32'h0000_FF01;
        offer(rq);
        rq = plain_request(REQ_POLL);
        rq.cur_pc = '1;
        rq.isa16 = 1'b1;
        offer(rq);
        rq = plain_request(REQ_READ);
        rq.reg_select = SEL_EPC;
        offer(rq);
        offer(plain_request(REQ_ERET));
        rq = plain_request(REQ_WRITE);
        rq.reg_select = SEL_CAUSE;
        rq.write_value = 32'h0080_0000;
        offer(rq);
        rq = plain_request(REQ_SET_IRQ);
        rq.irq_line = 3'd3;
        offer(rq);
        offer(plain_request(REQ_POLL));
        rq = plain_request(REQ_EXC);
        rq.cause_code = EXC_TLBL;
        rq.cur_pc = 32'h1234_5678;
        offer(rq);
        offer(plain_request(REQ_ERET));
        rq = plain_request(REQ_EXC);
        rq.cause_code = EXC_TLBS;
        rq.in_delay_slot = 1'b1;
        offer(rq);
        rq.cause_code = 5'd31;
        offer(rq);
        rq = plain_request(REQ_COPU);
        rq.cur_pc = '1;
        offer(rq);
        rq = plain_request(REQ_WRITE);
        rq.reg_select = SEL_ERREPC;
        rq.write_value = '1;
        offer(rq);
        rq.reg_select = SEL_STATUS;
        rq.write_value = 32'h0000_0004;
        offer(rq);
        offer(plain_request(REQ_ERET));
        rq = plain_request(REQ_DEBUG);
        rq.debug_kind = '1;
        rq.in_delay_slot = 1'b1;
        rq.cur_pc = '1;
        rq.isa16 = 1'b1;
        offer(rq);
        offer(plain_request(REQ_DEBUG));
        offer(plain_request(REQ_DERET));
        rq = plain_request(REQ_WRITE);
        rq.reg_select = SEL_UNUSED_LO;
        rq.write_value = '1;
        offer(rq);
        rq = plain_request(REQ_READ);
        rq.reg_select = SEL_UNUSED_HI;
        offer(rq);
        rq.reg_select = SEL_DEBUG;
        offer(rq);
        rq = plain_request(REQ_CLR_IRQ);
        rq.irq_line = 3'd7;
        offer(rq);
        rq.irq_line = 3'd0;
        offer(rq);

        run_phase(32'hFFFF_FFFF, 1'b1, 100, 1'b0);
        run_phase(32'h0000_0000, 1'b0, 100, 1'b1);
        run_phase($urandom, 1'b1, 100, 1'b0);
        run_phase($urandom, 1'b0, 100, 1'b0);

        drain();
        repeat (4) @(posedge aclk);
        if (book.mismatches == 0 && book.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/meiu_pkg.sv
src/mips_exception_interrupt_unit_top.sv
src/meiu_checker.sv
dv/mips_exception_interrupt_unit_top_tb.sv
